// ===== rtl/vrc_pkg.sv =====
`default_nettype none

package vrc_pkg;

  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BG_RED   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BG_GREEN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_BG_BLUE  = CFG_IDX_W'(3);

  localparam logic [15:0] SPACING_RESET = 16'd4096;
  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic [16:0] SUM_MAX       = 17'd131071;
  localparam logic [15:0] OUT_MAX       = 16'hFFFF;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_X,
    OP_MUL_P,
    OP_ROM,
    OP_INTERP_LO,
    OP_INTERP_HI,
    OP_WEIGHT,
    OP_COLOR,
    OP_PIXEL
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_of_table;
  } status_t;

  typedef struct packed {
    logic [15:0] spacing;
    logic [15:0] bg_red;
    logic [15:0] bg_green;
    logic [15:0] bg_blue;
  } cfg_t;

  // Shift-subtract quotient, evaluated at elaboration only.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-16*idx/entries) in Q1.16: Taylor series of exp(-y/256) in Q1.31,
  // squared eight times, rounded half up.
  function automatic logic [16:0] exp_entry(int unsigned idx, int unsigned entries);
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] v;
    y  = udiv64(64'(idx) << 36, 64'(entries));
    z  = y >> 9;
    t2 = ((z * z) >> 31) >> 1;
    t3 = ((t2 * z) >> 31) / 64'd3;
    t4 = ((t3 * z) >> 31) >> 2;
    v  = (64'd1 << 31) - z + t2 - t3 + t4;
    for (int k = 0; k < 8; k++) begin
      v = (v * v + (64'd1 << 30)) >> 31;
    end
    return 17'((v + (64'd1 << 14)) >> 15);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vrc_sample_if.sv =====
`default_nettype none

interface vrc_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] density;
  logic [15:0] sample_red;
  logic [15:0] sample_green;
  logic [15:0] sample_blue;
  logic        last_sample;

  modport source (
    output valid, density, sample_red, sample_green, sample_blue, last_sample,
    input  ready
  );
  modport sink (
    input  valid, density, sample_red, sample_green, sample_blue, last_sample,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/vrc_pixel_if.sv =====
`default_nettype none

interface vrc_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_red;
  logic [15:0] pixel_green;
  logic [15:0] pixel_blue;
  logic [15:0] pixel_opacity;

  modport source (
    output valid, pixel_red, pixel_green, pixel_blue, pixel_opacity,
    input  ready
  );
  modport sink (
    input  valid, pixel_red, pixel_green, pixel_blue, pixel_opacity,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/vrc_cfg_if.sv =====
`default_nettype none

interface vrc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vrc_pkg::CFG_IDX_W-1:0]  index;
  logic [15:0]                    data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/vrc_exp_rom.sv =====
`default_nettype none

module vrc_exp_rom #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [$clog2(ENTRIES)-1:0]  addr_i,
  output logic [16:0]                 lo_o,
  output logic [16:0]                 hi_o
);

  localparam int unsigned IW = $clog2(ENTRIES);

  logic [16:0] rom_w [ENTRIES];
  logic [16:0] lo_q;
  logic [16:0] hi_q;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_entry
    localparam logic [16:0] ENTRY = vrc_pkg::exp_entry(i, ENTRIES);
    assign rom_w[i] = ENTRY;
  end

  // The entry past the end of the table reads as zero.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      lo_q <= rom_w[addr_i];
      if (addr_i == IW'(ENTRIES - 1)) begin
        hi_q <= '0;
      end else begin
        hi_q <= rom_w[addr_i + IW'(1)];
      end
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

`default_nettype wire

// ===== rtl/vrc_datapath.sv =====
`default_nettype none

module vrc_datapath #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vrc_pkg::cmd_t     cmd_i,
  input  vrc_pkg::cfg_t     cfg_i,
  input  logic [15:0]       density_i,
  input  logic [15:0]       sample_red_i,
  input  logic [15:0]       sample_green_i,
  input  logic [15:0]       sample_blue_i,
  input  logic              last_sample_i,
  output vrc_pkg::status_t  status_o,
  output logic [15:0]       pixel_red_o,
  output logic [15:0]       pixel_green_o,
  output logic [15:0]       pixel_blue_o,
  output logic [15:0]       pixel_opacity_o
);

  localparam int unsigned NW    = $clog2(ENTRIES + 1);
  localparam int unsigned IW    = $clog2(ENTRIES);
  localparam int unsigned P_W   = 32 + NW;
  localparam int unsigned IDX_W = P_W - 24;
  localparam int unsigned MA_W  = 32;
  localparam int unsigned MB_W  = (NW > 17) ? NW : 17;
  localparam int unsigned PR_W  = MA_W + MB_W;
  localparam int unsigned LANES = 3;

  logic [15:0]      density_q;
  logic [15:0]      color_q  [LANES];
  logic             last_q;
  logic [31:0]      x_q;
  logic [P_W-1:0]   p_q;
  logic [15:0]      frac_q;
  logic [33:0]      acc_q;
  logic [16:0]      alpha_q;
  logic [16:0]      weight_q;
  logic [16:0]      trans_q;
  logic [16:0]      sum_q    [LANES];
  logic [16:0]      sum_op_q;
  logic [15:0]      pix_q    [LANES];
  logic [15:0]      opac_q;

  logic [MA_W-1:0]  mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [PR_W-1:0]  mul_p;
  logic [IDX_W-1:0] idx_full;
  logic             oot;
  logic [16:0]      rom_lo;
  logic [16:0]      rom_hi;
  logic [34:0]      interp_sum;
  logic [33:0]      wt_round;
  logic [33:0]      trans_p;
  logic [16:0]      rest;
  logic [15:0]      bg_w     [LANES];
  logic [16:0]      lane_a;
  logic [15:0]      lane_b   [LANES];
  logic [32:0]      lane_p   [LANES];
  logic [16:0]      lane_r   [LANES];
  logic [17:0]      lane_s   [LANES];
  logic [17:0]      op_s;

  assign bg_w[0] = cfg_i.bg_red;
  assign bg_w[1] = cfg_i.bg_green;
  assign bg_w[2] = cfg_i.bg_blue;

  // Shared scalar multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      vrc_pkg::OP_MUL_X: begin
        mul_a = MA_W'(density_q);
        mul_b = MB_W'(cfg_i.spacing);
      end
      vrc_pkg::OP_MUL_P: begin
        mul_a = x_q;
        mul_b = MB_W'(ENTRIES);
      end
      vrc_pkg::OP_INTERP_LO: begin
        mul_a = MA_W'(rom_lo);
        mul_b = MB_W'(vrc_pkg::ONE_Q16 - 17'(frac_q));
      end
      vrc_pkg::OP_INTERP_HI: begin
        mul_a = MA_W'(rom_hi);
        mul_b = MB_W'(frac_q);
      end
      vrc_pkg::OP_WEIGHT: begin
        mul_a = MA_W'(alpha_q);
        mul_b = MB_W'(trans_q);
      end
      default: begin
      end
    endcase
  end

  assign mul_p = PR_W'(mul_a) * PR_W'(mul_b);

  assign idx_full = p_q[P_W-1:24];
  assign oot      = (idx_full >= IDX_W'(ENTRIES));

  vrc_exp_rom #(
    .ENTRIES (ENTRIES)
  ) u_exp_rom (
    .clk_i   (clk_i),
    .rd_en_i (cmd_i.op == vrc_pkg::OP_ROM),
    .addr_i  (idx_full[IW-1:0]),
    .lo_o    (rom_lo),
    .hi_o    (rom_hi)
  );

  assign interp_sum = 35'(acc_q) + 35'(mul_p[33:0]) + 35'd32768;
  assign wt_round   = mul_p[33:0] + 34'd32768;
  assign trans_p    = 34'(trans_q) * 34'(vrc_pkg::ONE_Q16 - alpha_q) + 34'd32768;

  assign rest = vrc_pkg::ONE_Q16 -
                ((sum_op_q > vrc_pkg::ONE_Q16) ? vrc_pkg::ONE_Q16 : sum_op_q);

  // Color lanes: weight times radiance, or remaining share times background.
  assign lane_a = (cmd_i.op == vrc_pkg::OP_PIXEL) ? rest : weight_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_b[l] = (cmd_i.op == vrc_pkg::OP_PIXEL) ? bg_w[l] : color_q[l];
      lane_p[l] = 33'(lane_a) * 33'(lane_b[l]) + 33'd32768;
      lane_r[l] = lane_p[l][32:16];
      lane_s[l] = 18'(sum_q[l]) + 18'(lane_r[l]);
    end
  end

  assign op_s = 18'(sum_op_q) + 18'(weight_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_q  <= vrc_pkg::ONE_Q16;
      sum_op_q <= '0;
      for (int l = 0; l < LANES; l++) begin
        sum_q[l] <= '0;
      end
    end else begin
      case (cmd_i.op)
        vrc_pkg::OP_WEIGHT: begin
          trans_q <= trans_p[32:16];
        end
        vrc_pkg::OP_COLOR: begin
          for (int l = 0; l < LANES; l++) begin
            sum_q[l] <= (lane_s[l] > 18'(vrc_pkg::SUM_MAX)) ? vrc_pkg::SUM_MAX
                                                             : lane_s[l][16:0];
          end
          sum_op_q <= (op_s > 18'(vrc_pkg::SUM_MAX)) ? vrc_pkg::SUM_MAX : op_s[16:0];
        end
        vrc_pkg::OP_PIXEL: begin
          trans_q  <= vrc_pkg::ONE_Q16;
          sum_op_q <= '0;
          for (int l = 0; l < LANES; l++) begin
            sum_q[l] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      vrc_pkg::OP_LOAD: begin
        density_q  <= density_i;
        color_q[0] <= sample_red_i;
        color_q[1] <= sample_green_i;
        color_q[2] <= sample_blue_i;
        last_q     <= last_sample_i;
        alpha_q    <= (last_sample_i && (density_i != '0)) ? vrc_pkg::ONE_Q16 : '0;
      end
      vrc_pkg::OP_MUL_X: begin
        x_q <= mul_p[31:0];
      end
      vrc_pkg::OP_MUL_P: begin
        p_q <= mul_p[P_W-1:0];
      end
      vrc_pkg::OP_ROM: begin
        frac_q <= p_q[23:8];
        if (oot) begin
          alpha_q <= vrc_pkg::ONE_Q16;
        end
      end
      vrc_pkg::OP_INTERP_LO: begin
        acc_q <= mul_p[33:0];
      end
      vrc_pkg::OP_INTERP_HI: begin
        alpha_q <= vrc_pkg::ONE_Q16 - interp_sum[32:16];
      end
      vrc_pkg::OP_WEIGHT: begin
        weight_q <= wt_round[32:16];
      end
      vrc_pkg::OP_PIXEL: begin
        for (int l = 0; l < LANES; l++) begin
          pix_q[l] <= (lane_s[l] > 18'(vrc_pkg::OUT_MAX)) ? vrc_pkg::OUT_MAX
                                                          : lane_s[l][15:0];
        end
        opac_q <= (sum_op_q > 17'(vrc_pkg::OUT_MAX)) ? vrc_pkg::OUT_MAX
                                                     : sum_op_q[15:0];
      end
      default: begin
      end
    endcase
  end

  assign status_o.last         = last_q;
  assign status_o.out_of_table = oot;

  assign pixel_red_o     = pix_q[0];
  assign pixel_green_o   = pix_q[1];
  assign pixel_blue_o    = pix_q[2];
  assign pixel_opacity_o = opac_q;

endmodule

`default_nettype wire

// ===== rtl/vrc_ctrl.sv =====
`default_nettype none

module vrc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  vrc_pkg::status_t  status_i,
  output vrc_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_P,
    ST_ROM,
    ST_INTERP_LO,
    ST_INTERP_HI,
    ST_WEIGHT,
    ST_COLOR,
    ST_PIXEL
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = vrc_pkg::OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = vrc_pkg::OP_LOAD;
          state_d  = in_last_i ? ST_WEIGHT : ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        cmd_o.op = vrc_pkg::OP_MUL_X;
        state_d  = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd_o.op = vrc_pkg::OP_MUL_P;
        state_d  = ST_ROM;
      end
      ST_ROM: begin
        cmd_o.op = vrc_pkg::OP_ROM;
        state_d  = status_i.out_of_table ? ST_WEIGHT : ST_INTERP_LO;
      end
      ST_INTERP_LO: begin
        cmd_o.op = vrc_pkg::OP_INTERP_LO;
        state_d  = ST_INTERP_HI;
      end
      ST_INTERP_HI: begin
        cmd_o.op = vrc_pkg::OP_INTERP_HI;
        state_d  = ST_WEIGHT;
      end
      ST_WEIGHT: begin
        cmd_o.op = vrc_pkg::OP_WEIGHT;
        state_d  = ST_COLOR;
      end
      ST_COLOR: begin
        cmd_o.op = vrc_pkg::OP_COLOR;
        state_d  = status_i.last ? ST_PIXEL : ST_IDLE;
      end
      ST_PIXEL: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = vrc_pkg::OP_PIXEL;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/volume_render_ray_compositing.sv =====
// Ray compositor: samples in on sample_i, one pixel out on pixel_o per ray.
// sample_i carries density (Q8.8), radiance (Q0.16) and last_sample; a
// request is taken when valid and ready are both high. The block works on
// one sample at a time: ready is high only while the sequencer is idle.
// An inner sample runs load, density*spacing, table scaling, table read, two
// interpolation products, weight and color update, the products on the single
// shared multiplier (table read skips to weight when density*spacing runs
// past the exp table). A last sample runs load, weight, color update and a
// pixel write; pixel_o.valid then stays high until pixel_o.ready takes it.
// The pixel register lets the next ray start while a pixel waits. If the
// receiver stalls, the following last sample holds in its final step until
// the register is free.
// cfg_i writes registers 0..3 (spacing Q4.12, background red, green, blue);
// it is always ready and must be used only while the block is idle.
// Reset sets spacing to 1.0, the background to black, transmittance to 1.0
// and all sums to zero; the exp table is constant and needs no fill.
`default_nettype none

module volume_render_ray_compositing #(
  parameter int unsigned EXP_TABLE_ENTRIES = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vrc_sample_if.sink   sample_i,
  vrc_pixel_if.source  pixel_o,
  vrc_cfg_if.sink      cfg_i
);

  vrc_pkg::cfg_t    cfg_q;
  vrc_pkg::cmd_t    cmd;
  vrc_pkg::status_t status;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spacing  <= vrc_pkg::SPACING_RESET;
      cfg_q.bg_red   <= '0;
      cfg_q.bg_green <= '0;
      cfg_q.bg_blue  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        vrc_pkg::CFG_SPACING:  cfg_q.spacing  <= cfg_i.data;
        vrc_pkg::CFG_BG_RED:   cfg_q.bg_red   <= cfg_i.data;
        vrc_pkg::CFG_BG_GREEN: cfg_q.bg_green <= cfg_i.data;
        vrc_pkg::CFG_BG_BLUE:  cfg_q.bg_blue  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  vrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_last_i   (sample_i.last_sample),
    .in_ready_o  (sample_i.ready),
    .out_ready_i (pixel_o.ready),
    .out_valid_o (pixel_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  vrc_datapath #(
    .ENTRIES (EXP_TABLE_ENTRIES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_i           (cfg_q),
    .density_i       (sample_i.density),
    .sample_red_i    (sample_i.sample_red),
    .sample_green_i  (sample_i.sample_green),
    .sample_blue_i   (sample_i.sample_blue),
    .last_sample_i   (sample_i.last_sample),
    .status_o        (status),
    .pixel_red_o     (pixel_o.pixel_red),
    .pixel_green_o   (pixel_o.pixel_green),
    .pixel_blue_o    (pixel_o.pixel_blue),
    .pixel_opacity_o (pixel_o.pixel_opacity)
  );

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.valid && sample_i.ready |=> !sample_i.ready)
    else $error("sample request taken while a sample is in flight");

  a_pixel_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == vrc_pkg::OP_PIXEL |-> !pixel_o.valid || pixel_o.ready)
    else $error("pixel register overwritten while still pending");

  a_interp_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == vrc_pkg::OP_INTERP_LO |-> !status.out_of_table)
    else $error("table interpolation past the end of the exp table");

  a_pixel_after_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == vrc_pkg::OP_PIXEL |-> $past(cmd.op) == vrc_pkg::OP_COLOR ||
                                    $past(cmd.op) == vrc_pkg::OP_NONE)
    else $error("pixel written without a finished color update");
`endif

endmodule

`default_nettype wire

// ===== tb/vrc_composite_checker.sv =====
`default_nettype none

module vrc_composite_checker #(
  parameter int unsigned EXP_TABLE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vrc_sample_if       sample_mon,
  vrc_pixel_if        pixel_mon,
  vrc_cfg_if          cfg_mon,
  output int unsigned pixel_errors,
  output int unsigned pixels_owed
);

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] opacity;
  } pixel_t;

  logic [16:0] decay_lut [EXP_TABLE_ENTRIES];
  logic [15:0] spacing;
  logic [15:0] bg_red;
  logic [15:0] bg_green;
  logic [15:0] bg_blue;
  logic [16:0] transmit;
  logic [16:0] acc_red;
  logic [16:0] acc_green;
  logic [16:0] acc_blue;
  logic [16:0] acc_opacity;
  pixel_t      owed_pixels [$];

  function automatic logic [16:0] decay_point(int unsigned k);
    longint unsigned n_ent;
    longint unsigned arg;
    longint unsigned s2;
    longint unsigned s3;
    longint unsigned s4;
    longint unsigned acc;
    n_ent = EXP_TABLE_ENTRIES;
    arg = k;
    arg = ((arg << 36) / n_ent) >> 9;
    s2 = ((arg * arg) >> 31) / 2;
    s3 = ((s2 * arg) >> 31) / 3;
    s4 = ((s3 * arg) >> 31) / 4;
    acc = 64'h8000_0000 - arg + s2 - s3 + s4;
    repeat (8) acc = (acc * acc + 64'h4000_0000) >> 31;
    return 17'((acc + 64'h4000) >> 15);
  endfunction

  initial begin
    for (int k = 0; k < EXP_TABLE_ENTRIES; k++) decay_lut[k] = decay_point(k);
  end

  function automatic logic [16:0] mul_round(logic [16:0] a, logic [16:0] b);
    longint unsigned prod;
    prod = a;
    prod = prod * b + 64'd32768;
    return 17'(prod >> 16);
  endfunction

  function automatic logic [16:0] acc_add(logic [16:0] a, logic [16:0] b);
    logic [17:0] s;
    s = a + b;
    return (s > vrc_pkg::SUM_MAX) ? vrc_pkg::SUM_MAX : s[16:0];
  endfunction

  function automatic logic [16:0] table_decay(logic [15:0] dens);
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned lo;
    longint unsigned hi;
    pos = dens;
    pos = pos * spacing * EXP_TABLE_ENTRIES;
    idx = pos >> 24;
    frac = (pos >> 8) & 64'hFFFF;
    if (idx >= EXP_TABLE_ENTRIES) return '0;
    lo = decay_lut[idx];
    hi = (idx + 1 < EXP_TABLE_ENTRIES) ? decay_lut[idx + 1] : 17'd0;
    return 17'((lo * (64'd65536 - frac) + hi * frac + 64'd32768) >> 16);
  endfunction

  function automatic logic [15:0] blend(logic [16:0] sum, logic [15:0] bg,
                                        logic [16:0] rest);
    logic [17:0] v;
    v = sum + mul_round(rest, {1'b0, bg});
    return (v > vrc_pkg::OUT_MAX) ? vrc_pkg::OUT_MAX : v[15:0];
  endfunction

  task automatic report(string field, logic [15:0] want, logic [15:0] got);
    pixel_errors++;
    if (pixel_errors <= 10)
      $display("pixel %s mismatch: expected %0d, got %0d", field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [16:0] alpha;
    logic [16:0] weight;
    logic [16:0] rest;
    pixel_t      want;
    pixel_t      got;
    if (!rst_ni) begin
      spacing      = vrc_pkg::SPACING_RESET;
      bg_red       = '0;
      bg_green     = '0;
      bg_blue      = '0;
      transmit     = vrc_pkg::ONE_Q16;
      acc_red      = '0;
      acc_green    = '0;
      acc_blue     = '0;
      acc_opacity  = '0;
      pixel_errors = 0;
      owed_pixels.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          vrc_pkg::CFG_SPACING:  spacing  = cfg_mon.data;
          vrc_pkg::CFG_BG_RED:   bg_red   = cfg_mon.data;
          vrc_pkg::CFG_BG_GREEN: bg_green = cfg_mon.data;
          vrc_pkg::CFG_BG_BLUE:  bg_blue  = cfg_mon.data;
          default: ;
        endcase
      end
      if (sample_mon.valid && sample_mon.ready) begin
        if (sample_mon.last_sample)
          alpha = (sample_mon.density != 0) ? vrc_pkg::ONE_Q16 : 17'd0;
        else
          alpha = vrc_pkg::ONE_Q16 - table_decay(sample_mon.density);
        weight      = mul_round(alpha, transmit);
        acc_red     = acc_add(acc_red, mul_round(weight, {1'b0, sample_mon.sample_red}));
        acc_green   = acc_add(acc_green, mul_round(weight, {1'b0, sample_mon.sample_green}));
        acc_blue    = acc_add(acc_blue, mul_round(weight, {1'b0, sample_mon.sample_blue}));
        acc_opacity = acc_add(acc_opacity, weight);
        transmit    = mul_round(transmit, vrc_pkg::ONE_Q16 - alpha);
        if (sample_mon.last_sample) begin
          rest = vrc_pkg::ONE_Q16 -
                 ((acc_opacity > vrc_pkg::ONE_Q16) ? vrc_pkg::ONE_Q16 : acc_opacity);
          want.red     = blend(acc_red, bg_red, rest);
          want.green   = blend(acc_green, bg_green, rest);
          want.blue    = blend(acc_blue, bg_blue, rest);
          want.opacity = (acc_opacity > vrc_pkg::OUT_MAX) ? vrc_pkg::OUT_MAX
                                                          : acc_opacity[15:0];
          owed_pixels.insert(owed_pixels.size(), want);
          transmit    = vrc_pkg::ONE_Q16;
          acc_red     = '0;
          acc_green   = '0;
          acc_blue    = '0;
          acc_opacity = '0;
        end
      end
      if (pixel_mon.valid && pixel_mon.ready) begin
        got.red     = pixel_mon.pixel_red;
        got.green   = pixel_mon.pixel_green;
        got.blue    = pixel_mon.pixel_blue;
        got.opacity = pixel_mon.pixel_opacity;
        if (owed_pixels.size() == 0) begin
          pixel_errors++;
          if (pixel_errors <= 10)
            $display("pixel with no ray behind it: %h", got);
        end else begin
          want = owed_pixels.pop_front();
          if (got.red !== want.red) report("red", want.red, got.red);
          if (got.green !== want.green) report("green", want.green, got.green);
          if (got.blue !== want.blue) report("blue", want.blue, got.blue);
          if (got.opacity !== want.opacity) report("opacity", want.opacity, got.opacity);
        end
      end
    end
    pixels_owed <= owed_pixels.size();
  end

endmodule

`default_nettype wire

// ===== tb/volume_render_ray_compositing_tb.sv =====
`default_nettype none

module volume_render_ray_compositing_tb;

  localparam int unsigned LUT_ENTRIES   = 256;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam logic [vrc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = '1;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        calm = 1'b0;
  logic        ray_calm = 1'b0;
  int unsigned ready_hold = 0;
  int unsigned pixel_errors;
  int unsigned pixels_owed;

  vrc_sample_if sample_ch ();
  vrc_pixel_if  pixel_ch ();
  vrc_cfg_if    cfg_ch ();

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  volume_render_ray_compositing #(
    .EXP_TABLE_ENTRIES(LUT_ENTRIES)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_ch),
    .pixel_o (pixel_ch),
    .cfg_i   (cfg_ch)
  );

  vrc_composite_checker #(
    .EXP_TABLE_ENTRIES(LUT_ENTRIES)
  ) composite_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_mon  (sample_ch),
    .pixel_mon   (pixel_ch),
    .cfg_mon     (cfg_ch),
    .pixel_errors(pixel_errors),
    .pixels_owed (pixels_owed)
  );

  function automatic int unsigned pick_gap(logic hush);
    int unsigned r;
    if (hush) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_level();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [15:0] pick_density();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r <= 5) return 16'($urandom_range(0, 16'h0400));
    if (r == 9) return 16'($urandom_range(1, 16));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm) begin
      pixel_ch.ready <= 1'b1;
    end else begin
      pixel_ch.ready <= ($urandom_range(0, 2) != 0);
      ready_hold     <= pick_gap(1'b0);
    end
  end

  task automatic push_sample(logic [15:0] dens, logic [15:0] red, logic [15:0] green,
                             logic [15:0] blue, logic last);
    int unsigned gap;
    gap = pick_gap(ray_calm);
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.density      <= dens;
    sample_ch.sample_red   <= red;
    sample_ch.sample_green <= green;
    sample_ch.sample_blue  <= blue;
    sample_ch.last_sample  <= last;
    do @(posedge clk_i); while (!(sample_ch.valid && sample_ch.ready));
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pixels_owed != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [vrc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_ray(int unsigned len);
    logic [15:0] tail;
    for (int i = 1; i < len; i++)
      push_sample(pick_density(), pick_level(), pick_level(), pick_level(), 1'b0);
    tail = $urandom_range(0, 1) ? 16'h0000 : pick_density();
    push_sample(tail, pick_level(), pick_level(), pick_level(), 1'b1);
  endtask

  task automatic random_config();
    logic [15:0] gap_q;
    settle();
    case ($urandom_range(0, 5))
      0:       gap_q = vrc_pkg::SPACING_RESET;
      1:       gap_q = 16'h0000;
      2:       gap_q = 16'hFFFF;
      3:       gap_q = 16'h0001;
      4:       gap_q = 16'($urandom_range(256, 8192));
      default: gap_q = 16'($urandom_range(0, 16'hFFFF));
    endcase
    write_reg(vrc_pkg::CFG_SPACING, gap_q);
    if ($urandom_range(0, 3) != 0) write_reg(vrc_pkg::CFG_BG_RED, pick_level());
    if ($urandom_range(0, 3) != 0) write_reg(vrc_pkg::CFG_BG_GREEN, pick_level());
    if ($urandom_range(0, 3) != 0) write_reg(vrc_pkg::CFG_BG_BLUE, pick_level());
    if ($urandom_range(0, 4) == 0)
      write_reg(vrc_pkg::CFG_IDX_W'($urandom_range(vrc_pkg::CFG_BG_BLUE + 1,
                                                   (1 << vrc_pkg::CFG_IDX_W) - 1)),
                pick_level());
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    rst_ni                 <= 1'b0;
    sample_ch.valid        <= 1'b0;
    sample_ch.density      <= '0;
    sample_ch.sample_red   <= '0;
    sample_ch.sample_green <= '0;
    sample_ch.sample_blue  <= '0;
    sample_ch.last_sample  <= 1'b0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= vrc_pkg::CFG_SPACING;
    cfg_ch.data            <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_sample(16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 1'b0);
    push_sample(16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_sample(16'h0100, 16'h1234, 16'hFFFF, 16'h0000, 1'b0);
    push_sample(16'h0FFF, 16'h0000, 16'h8000, 16'hFFFF, 1'b0);
    push_sample(16'h1000, 16'hFFFF, 16'h0001, 16'h7FFF, 1'b0);
    push_sample(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    settle();

    write_reg(vrc_pkg::CFG_SPACING, 16'h0000);
    write_reg(vrc_pkg::CFG_BG_RED, 16'hFFFF);
    write_reg(vrc_pkg::CFG_BG_GREEN, 16'hFFFF);
    write_reg(vrc_pkg::CFG_BG_BLUE, 16'hFFFF);
    push_sample(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    push_sample(16'h0000, 16'h5555, 16'hAAAA, 16'h0000, 1'b1);
    push_sample(16'h0040, 16'h8000, 16'h0000, 16'hFFFF, 1'b1);
    settle();

    write_reg(vrc_pkg::CFG_SPACING, 16'hFFFF);
    write_reg(vrc_pkg::CFG_BG_RED, 16'h8000);
    write_reg(vrc_pkg::CFG_BG_GREEN, 16'h0000);
    write_reg(vrc_pkg::CFG_BG_BLUE, 16'h0001);
    write_reg(CFG_UNMAPPED, 16'h0000);
    push_sample(16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    push_sample(16'h0100, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    push_sample(16'h0101, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    push_sample(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    settle();

    write_reg(vrc_pkg::CFG_SPACING, 16'h0010);
    write_reg(vrc_pkg::CFG_BG_GREEN, 16'hFFFF);
    push_sample(16'h0080, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_sample(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      random_config();
      sent = 0;
      while (sent < 100) begin
        ray_calm = ($urandom_range(0, 4) == 0);
        calm <= ray_calm;
        r = $urandom_range(0, 9);
        if (r <= 1) len = 1;
        else if (r <= 7) len = $urandom_range(2, 8);
        else if (r == 8) len = $urandom_range(9, 24);
        else len = $urandom_range(25, 40);
        send_ray(len);
        if ((phase == 1 && sent == 0) || $urandom_range(0, 19) == 0) drain();
        sent += len;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pixel_errors == 0 && pixels_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/vrc_pkg.sv
rtl/vrc_sample_if.sv
rtl/vrc_pixel_if.sv
rtl/vrc_cfg_if.sv
rtl/vrc_exp_rom.sv
rtl/vrc_datapath.sv
rtl/vrc_ctrl.sv
rtl/volume_render_ray_compositing.sv
tb/vrc_composite_checker.sv
tb/volume_render_ray_compositing_tb.sv
